@@ rtl/core/sid_pkg.sv @@
// Shared types for the signed integer divider.
// Holds the controller state encoding and the command and status
// structs passed between the controller and the datapath.
package sid_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FIN
	} sid_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} sid_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} sid_sts_t;

endpackage

@@ rtl/core/sid_if.sv @@
// Valid/ready channel interfaces for the signed integer divider.
// One for the operand items, one for the result items; no dependencies.
interface sid_in_if #(
	parameter int W = 32
);
	logic         valid;
	logic         ready;
	logic [W-1:0] dividend;
	logic [W-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface sid_out_if #(
	parameter int W = 32
);
	logic         valid;
	logic         ready;
	logic [W-1:0] quotient;
	logic         divide_by_zero;
	logic         overflowed;

	modport source (output valid, output quotient, output divide_by_zero,
		output overflowed, input ready);
	modport sink (input valid, input quotient, input divide_by_zero,
		input overflowed, output ready);
endinterface

@@ rtl/core/signed_integer_divider.sv @@
// Signed integer divider, truncating toward zero.
// Operand items arrive on req (dividend, divisor); one result item per
// operand item leaves on rsp (quotient, divide_by_zero, overflowed).
// Both channels move an item when valid and ready are high at a clock edge.
// The divider works on one item at a time: req.ready is high only while
// idle. The operands load at the accepting edge, then DATA_WIDTH iterations
// of the radix-2 restoring subtract follow (one quotient bit per cycle) and
// a final step fixes the sign and registers the result. A new item is
// accepted, at the earliest, the cycle after the result is written.
// The result register holds its item until rsp.ready; the next division
// may run meanwhile and waits in its final cycle if the register is still
// full. A zero divisor gives quotient 0 with divide_by_zero set; the most
// negative value divided by minus one gives the largest positive value with
// overflowed set. Reset (arst_n low) returns to idle and drops rsp.valid.
// Depends on sid_pkg, sid_if, sid_ctrl and sid_datapath.
module signed_integer_divider
	import sid_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	sid_in_if.sink   req,
	sid_out_if.source rsp
);

	sid_cmd_t cmd;
	sid_sts_t sts;

	sid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sid_datapath #(
		.W (DATA_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.dividend       (req.dividend),
		.divisor        (req.divisor),
		.quotient       (rsp.quotient),
		.divide_by_zero (rsp.divide_by_zero),
		.overflowed     (rsp.overflowed)
	);

endmodule

@@ rtl/core/sid_ctrl.sv @@
// Controller for the signed integer divider.
// Sequences load, iteration and result commit; depends on sid_pkg.
module sid_ctrl
	import sid_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output sid_cmd_t cmd,
	input  sid_sts_t sts
);

	sid_state_t state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// Wait here while the previous result has not been taken.
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/sid_datapath.sv @@
// Datapath for the signed integer divider: operand magnitudes, a radix-2
// restoring divide iteration, sign fix-up and the result register.
// Depends on sid_pkg for the command and status structs.
module sid_datapath
	import sid_pkg::*;
#(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  sid_cmd_t     cmd,
	output sid_sts_t     sts,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quotient,
	output logic         divide_by_zero,
	output logic         overflowed
);

	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);
	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

	logic [CW-1:0] cnt_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic          neg_q;
	logic          zero_q;
	logic [W-1:0]  quot_out_q;
	logic          dbz_out_q;
	logic          ovf_out_q;

	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;
	logic [W:0]   rem_shift;
	logic [W:0]   diff;
	logic         fits;
	logic [W-1:0] quot_fix;
	logic         ovf_fix;

	assign mag_a = dividend[W-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b = divisor[W-1] ? (~divisor + 1'b1) : divisor;

	assign rem_shift = {rem_q[W-1:0], quo_q[W-1]};
	assign diff      = rem_shift - {1'b0, dvs_q};
	assign fits      = !diff[W];

	assign sts.last = (cnt_q == '0);

	// Only the most negative value over minus one exceeds the positive range.
	always_comb begin
		quot_fix = quo_q;
		ovf_fix  = 1'b0;
		if (zero_q) begin
			quot_fix = '0;
		end else if (neg_q) begin
			quot_fix = ~quo_q + 1'b1;
		end else if (quo_q[W-1]) begin
			quot_fix = MAX_POS;
			ovf_fix  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= CNT_LAST;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= '0;
			quo_q  <= mag_a;
			dvs_q  <= mag_b;
			neg_q  <= dividend[W-1] ^ divisor[W-1];
			zero_q <= (divisor == '0);
		end else if (cmd.step) begin
			rem_q <= fits ? diff : rem_shift;
			quo_q <= {quo_q[W-2:0], fits};
		end
		if (cmd.commit) begin
			quot_out_q <= quot_fix;
			dbz_out_q  <= zero_q;
			ovf_out_q  <= ovf_fix;
		end
	end

	assign quotient       = quot_out_q;
	assign divide_by_zero = dbz_out_q;
	assign overflowed     = ovf_out_q;

endmodule

@@ rtl/core/sid_checker.sv @@
// Port-level checks for the signed integer divider, with the bind that
// attaches them to the top level. Depends on signed_integer_divider.
module sid_checker #(
	parameter int W = 32
) (
	input logic         clk,
	input logic         arst_n,
	input logic         req_valid,
	input logic         req_ready,
	input logic         rsp_valid,
	input logic         rsp_ready,
	input logic [W-1:0] quotient,
	input logic         divide_by_zero,
	input logic         overflowed
);

	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

	// A result item waits until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item dropped while stalled");

	// One item at a time: acceptance closes the input side.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("operand accepted while a division is running");

	a_dbz_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && divide_by_zero |-> quotient == '0 && !overflowed)
		else $error("zero divisor result is not a clean zero");

	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflowed |-> quotient == MAX_POS)
		else $error("overflowed result is not saturated");

endmodule

bind signed_integer_divider sid_checker #(
	.W (DATA_WIDTH)
) u_sid_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.quotient       (rsp.quotient),
	.divide_by_zero (rsp.divide_by_zero),
	.overflowed     (rsp.overflowed)
);

@@ verif/tb_signed_integer_divider.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for signed_integer_divider.
// Drives operand items on sid_in_if, checks each result item on sid_out_if
// against an in-bench model of truncating signed division.
module tb_signed_integer_divider;

	localparam int W = 32;
	localparam int HOLD_OFF_AT = 400;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CALM_TAIL = 200;
	localparam int RANDOM_OPS = 1600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 2 * W + 10;

	localparam logic [W-1:0] MOST_NEG = {1'b1, {(W - 1){1'b0}}};
	localparam logic [W-1:0] MOST_POS = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] MINUS_ONE = '1;
	localparam logic [W-1:0] ZERO = '0;

	typedef struct {
		logic [W-1:0] dividend;
		logic [W-1:0] divisor;
		bit           drain_first;
	} div_op_t;

	typedef struct packed {
		logic [W-1:0] quotient;
		logic         divide_by_zero;
		logic         overflowed;
	} quot_result_t;

	logic clk = 1'b0;
	logic arst_n;

	sid_in_if #(.W(W)) req_ch ();
	sid_out_if #(.W(W)) rsp_ch ();

	signed_integer_divider #(
		.DATA_WIDTH(W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	div_op_t      ops_pending[$];
	quot_result_t quotients_due[$];
	div_op_t      next_op;
	logic         req_fire;
	int           ops_accepted;
	int           results_seen;
	int           ops_total;
	int           fail_count;
	int           gap_left;
	int           stall_left;
	int           hold_left;
	bit           hold_done;
	int           idle_cycles;
	logic         calm;

	// In the tail of the run neither side starts a new gap or stall.
	assign calm = (ops_total - ops_accepted) < CALM_TAIL;

	function automatic quot_result_t predict_quotient(logic [W-1:0] num, logic [W-1:0] den);
		quot_result_t r;
		logic [W-1:0] num_mag;
		logic [W-1:0] den_mag;
		logic [W-1:0] q_mag;
		r = '0;
		if (den == ZERO) begin
			r.divide_by_zero = 1'b1;
		end else begin
			// Unsigned W-bit magnitudes hold the most negative value exactly.
			num_mag = num[W-1] ? -num : num;
			den_mag = den[W-1] ? -den : den;
			q_mag = num_mag / den_mag;
			if (num[W-1] != den[W-1]) begin
				r.quotient = -q_mag;
			end else if (q_mag > MOST_POS) begin
				r.quotient = MOST_POS;
				r.overflowed = 1'b1;
			end else begin
				r.quotient = q_mag;
			end
		end
		return r;
	endfunction

	function automatic logic [W-1:0] rand_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[W-1:0];
	endfunction

	function automatic logic [W-1:0] rand_signed_mag();
		logic [W-1:0] v;
		v = rand_word() >> $urandom_range(0, W - 1);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic [W-1:0] pick_corner();
		case ($urandom_range(0, 5))
			0: return ZERO;
			1: return 1;
			2: return MINUS_ONE;
			3: return MOST_NEG;
			4: return MOST_POS;
			default: return MOST_NEG + 1;
		endcase
	endfunction

	function automatic div_op_t rand_division();
		div_op_t      op;
		logic [W-1:0] small_val;
		logic [W-1:0] factor;
		op.drain_first = 1'b0;
		small_val = $urandom_range(0, 31);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				op.dividend = rand_word();
				op.divisor = rand_word();
			end
			4: begin
				op.dividend = rand_word();
				op.divisor = small_val - 16;
			end
			5: begin
				op.dividend = $urandom_range(0, 511) - 256;
				op.divisor = small_val - 16;
			end
			6: begin
				op.dividend = rand_word();
				op.divisor = ZERO;
			end
			7: begin
				op.dividend = pick_corner();
				op.divisor = pick_corner();
			end
			8: begin
				// Near-exact multiples exercise the remainder boundary.
				op.divisor = rand_signed_mag();
				factor = rand_signed_mag();
				op.dividend = op.divisor * factor + $urandom_range(0, 2) - 1;
			end
			default: begin
				op.dividend = rand_signed_mag();
				op.divisor = rand_signed_mag();
			end
		endcase
		return op;
	endfunction

	task automatic add_op(logic [W-1:0] num, logic [W-1:0] den, bit drain);
		div_op_t op;
		op.dividend = num;
		op.divisor = den;
		op.drain_first = drain;
		ops_pending.push_back(op);
	endtask

	// Sender: a new item goes out at the falling edge after the last one moved, unless a gap or a drain wait holds it.
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_fire)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (ops_pending.size() == 0 ||
					(ops_pending[0].drain_first && quotients_due.size() != 0)) begin
				req_ch.valid <= 1'b0;
			end else begin
				next_op = ops_pending.pop_front();
				req_ch.dividend <= next_op.dividend;
				req_ch.divisor <= next_op.divisor;
				req_ch.valid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(1, 19);
				end
			end
		end
	end

	// Receiver: random stall bursts plus one long hold-off while the sender keeps going.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= HOLD_OFF_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_OFF_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 18);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: results are checked before new expectations are queued.
	always @(posedge clk) begin
		if (arst_n) begin
			req_fire <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (quotients_due.size() == 0) begin
					$error("unexpected result item: quotient %0d", $signed(rsp_ch.quotient));
					fail_count++;
				end else begin
					quot_result_t exp_r;
					exp_r = quotients_due.pop_front();
					if (rsp_ch.quotient !== exp_r.quotient) begin
						$error("quotient: expected %0d, got %0d",
							$signed(exp_r.quotient), $signed(rsp_ch.quotient));
						fail_count++;
					end
					if (rsp_ch.divide_by_zero !== exp_r.divide_by_zero) begin
						$error("divide_by_zero: expected %0b, got %0b",
							exp_r.divide_by_zero, rsp_ch.divide_by_zero);
						fail_count++;
					end
					if (rsp_ch.overflowed !== exp_r.overflowed) begin
						$error("overflowed: expected %0b, got %0b",
							exp_r.overflowed, rsp_ch.overflowed);
						fail_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				quotients_due.push_back(predict_quotient(req_ch.dividend, req_ch.divisor));
				ops_accepted++;
			end
		end else begin
			req_fire <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.dividend = '0;
		req_ch.divisor = '0;
		rsp_ch.ready = 1'b0;
		req_fire = 1'b0;
		ops_accepted = 0;
		results_seen = 0;
		fail_count = 0;
		gap_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		idle_cycles = 0;

		// Directed part: zero divisor, zero dividend, the overflowing case and extremes.
		add_op(ZERO, ZERO, 1'b0);
		add_op(ZERO, 5, 1'b0);
		add_op(ZERO, -5, 1'b0);
		add_op(MOST_NEG, MINUS_ONE, 1'b0);
		add_op(MOST_NEG, 1, 1'b0);
		add_op(MOST_NEG, MOST_NEG, 1'b0);
		add_op(MOST_POS, MOST_POS, 1'b0);
		add_op(MOST_POS, MINUS_ONE, 1'b0);
		add_op(MOST_NEG, ZERO, 1'b0);
		add_op(MOST_POS, ZERO, 1'b0);
		add_op(MINUS_ONE, ZERO, 1'b0);
		add_op(7, 2, 1'b0);
		add_op(-7, 2, 1'b0);
		add_op(7, -2, 1'b0);
		add_op(-7, -2, 1'b0);
		add_op(1, MOST_POS, 1'b0);
		add_op(MOST_NEG, MOST_POS, 1'b0);
		add_op(MOST_POS, MOST_NEG, 1'b0);
		add_op(MINUS_ONE, MINUS_ONE, 1'b0);
		add_op(5, 7, 1'b0);
		add_op(100, MINUS_ONE, 1'b0);
		add_op(MOST_NEG, 2, 1'b0);
		add_op(MOST_NEG, -2, 1'b0);
		add_op(MOST_POS, 1, 1'b0);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			next_op = rand_division();
			// The sender waits for the block to drain at the start and in the middle.
			next_op.drain_first = (i == 0) || (i == RANDOM_OPS / 2);
			ops_pending.push_back(next_op);
		end
		ops_total = ops_pending.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(ops_accepted == ops_total && quotients_due.size() == 0)) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && quotients_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/sid_pkg.sv
rtl/core/sid_if.sv
rtl/core/sid_ctrl.sv
rtl/core/sid_datapath.sv
rtl/core/signed_integer_divider.sv
rtl/core/sid_checker.sv
verif/tb_signed_integer_divider.sv
